[sv/markdown_block_classifier_core_assert.svh]
// Assertion macros used by the markdown block classifier RTL.
`ifndef MARKDOWN_BLOCK_CLASSIFIER_CORE_ASSERT_SVH
`define MARKDOWN_BLOCK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mbc_pkg.sv]
// Package with types, constants and codes of the markdown block classifier.
`default_nettype none

package mbc_pkg;

  localparam int LEAD_DEPTH = 16;
  localparam int LEAD_CNT_W = $clog2(LEAD_DEPTH + 1);
  localparam int LEAD_IDX_W = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;

  localparam logic [2:0] MAX_LEVEL = 3'd6;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_OVER = 3'd1,
    PH_HASH = 3'd2,
    PH_GAP  = 3'd3,
    PH_BODY = 3'd4,
    PH_PARA = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EV_TEXT    = 3'd0,
    EV_P_OPEN  = 3'd1,
    EV_P_CLOSE = 3'd2,
    EV_H_OPEN  = 3'd3,
    EV_H_CLOSE = 3'd4,
    EV_DOC_END = 3'd5
  } event_kind_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DISPATCH,
    OP_LEAD_ADD,
    OP_HASH_START,
    OP_HASH_INC,
    OP_SET_FLAG,
    OP_NEXT_B,
    OP_JOIN,
    OP_LEAD_POP,
    OP_HASH_POP,
    OP_TEXT,
    OP_PCLOSE,
    OP_HOPEN,
    OP_HCLOSE,
    OP_LINE_RESET,
    OP_DOC_END,
    OP_FINISH
  } op_e;

  typedef enum logic [4:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_FEED,
    CS_JOIN,
    CS_LEAD,
    CS_HASHES,
    CS_TEXT,
    CS_CLOSEH,
    CS_HOPEN,
    CS_NEXT,
    CS_ELINE,
    CS_ELCLOSE,
    CS_HCLOSE,
    CS_ELDONE,
    CS_ENDCLOSE,
    CS_DOCEND,
    CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    op_e  op;
    logic take;
  } cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   cur_ws;
    logic   cur_space;
    logic   cur_hash;
    logic   lead_zero;
    logic   lead_one;
    logic   hc_lt_max;
    logic   hc_one;
    logic   b_is_cr;
    logic   is_eol;
    logic   is_end;
    logic   held;
    logic   pend;
    logic   in_heading;
    logic   stage_v;
    logic   op_done;
    logic   in_fire;
  } status_t;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  data;
    logic [2:0]  level;
    logic        flag;
  } event_t;

endpackage

`default_nettype wire

[sv/mbc_if.sv]
// Valid/ready channel interfaces for text input and event output.
`default_nettype none

interface mbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface mbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] out_byte;
  logic [2:0] head_level;
  logic       lead_overflow;
  logic       last_of_run;

  modport source (output valid, output event_kind, output out_byte, output head_level,
                  output lead_overflow, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input out_byte, input head_level,
                input lead_overflow, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/markdown_block_classifier_core.sv]
// An input transaction is taken at idle, dispatched, then walked through its decision and
// event steps to the finish step; a byte may flush up to 16 buffered blanks.
// Throughput: one transaction at a time; the sequencer emits at most one event per cycle,
// and the output register lets the next transaction start while the last event waits.
// Reset: asynchronous, clears line state and empties the event stage; no clearing pass.
`default_nettype none
`include "markdown_block_classifier_core_assert.svh"

module markdown_block_classifier_core (
  input logic       clk_i,
  input logic       rst_ni,
  mbc_in_if.sink    in_i,
  mbc_out_if.source out_o
);
  import mbc_pkg::*;

  cmd_t    cmd;
  status_t st;

  mbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  mbc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .st_o   (st),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  `MBC_ASSERT_IMP(a_idle_stage_empty, clk_i, rst_ni, in_i.ready, !st.stage_v, "event left in stage at idle")
  `MBC_ASSERT_IMP(a_hclose_in_heading, clk_i, rst_ni, cmd.op == OP_HCLOSE, st.in_heading, "heading close without open heading")
  `MBC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "new transaction accepted while busy")
  `MBC_ASSERT_IMP(a_hopen_level, clk_i, rst_ni, out_o.valid && out_o.event_kind == EV_H_OPEN, out_o.head_level != 3'd0 && out_o.head_level <= MAX_LEVEL, "heading level out of range")

endmodule

`default_nettype wire

[sv/mbc_ctrl.sv]
// Sequencer that walks each input transaction through its event steps.
`default_nettype none

module mbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbc_pkg::status_t st_i,
  output mbc_pkg::cmd_t    cmd_o
);
  import mbc_pkg::*;

  ctrl_state_e state_q, state_d, nxt;
  logic        lead_like;

  assign lead_like = (st_i.phase == PH_LEAD) || (st_i.phase == PH_OVER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state; a step only advances once the datapath has finished its operation.
  always_comb begin
    nxt = state_q;
    case (state_q)
      CS_IDLE: begin
        if (st_i.in_fire) nxt = CS_DISPATCH;
      end
      CS_DISPATCH: begin
        if (st_i.is_eol) nxt = CS_ELINE;
        else if (st_i.held) nxt = CS_FEED;
        else if (st_i.b_is_cr) nxt = CS_FINISH;
        else nxt = CS_FEED;
      end
      CS_FEED: begin
        case (st_i.phase)
          PH_LEAD, PH_OVER: begin
            if (st_i.cur_ws) nxt = CS_NEXT;
            else if (st_i.cur_hash && st_i.phase == PH_LEAD && st_i.lead_zero) nxt = CS_NEXT;
            else nxt = CS_JOIN;
          end
          PH_HASH: begin
            if (st_i.cur_hash && st_i.hc_lt_max) nxt = CS_NEXT;
            else if (st_i.cur_space) nxt = CS_CLOSEH;
            else nxt = CS_JOIN;
          end
          PH_GAP: begin
            nxt = st_i.cur_space ? CS_NEXT : CS_TEXT;
          end
          default: nxt = CS_TEXT;
        endcase
      end
      CS_JOIN: begin
        if (st_i.phase == PH_HASH) nxt = CS_HASHES;
        else if (st_i.lead_zero) nxt = CS_TEXT;
        else nxt = CS_LEAD;
      end
      CS_LEAD: begin
        if (st_i.lead_one) nxt = CS_TEXT;
      end
      CS_HASHES: begin
        if (st_i.hc_one) nxt = st_i.is_eol ? CS_ELDONE : CS_TEXT;
      end
      CS_TEXT:   nxt = CS_NEXT;
      CS_CLOSEH: nxt = CS_HOPEN;
      CS_HOPEN:  nxt = CS_NEXT;
      CS_NEXT:   nxt = st_i.pend ? CS_FEED : CS_FINISH;
      CS_ELINE: begin
        if (lead_like) nxt = CS_ELCLOSE;
        else if (st_i.phase == PH_HASH) nxt = CS_JOIN;
        else if (st_i.phase == PH_GAP || st_i.phase == PH_BODY) nxt = CS_HCLOSE;
        else nxt = CS_ELDONE;
      end
      CS_ELCLOSE:  nxt = CS_ELDONE;
      CS_HCLOSE:   nxt = CS_ELDONE;
      CS_ELDONE:   nxt = st_i.is_end ? CS_ENDCLOSE : CS_FINISH;
      CS_ENDCLOSE: nxt = CS_DOCEND;
      CS_DOCEND:   nxt = CS_FINISH;
      CS_FINISH:   nxt = CS_IDLE;
      default:     nxt = CS_IDLE;
    endcase
    state_d = st_i.op_done ? nxt : state_q;
  end

  // Operation issued to the datapath in each state.
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.take = 1'b0;
    case (state_q)
      CS_IDLE:     cmd_o.take = 1'b1;
      CS_DISPATCH: cmd_o.op = OP_DISPATCH;
      CS_FEED: begin
        case (st_i.phase)
          PH_LEAD, PH_OVER: begin
            if (st_i.cur_ws) cmd_o.op = OP_LEAD_ADD;
            else if (st_i.cur_hash && st_i.phase == PH_LEAD && st_i.lead_zero) begin
              cmd_o.op = OP_HASH_START;
            end else cmd_o.op = OP_SET_FLAG;
          end
          PH_HASH: begin
            if (st_i.cur_hash && st_i.hc_lt_max) cmd_o.op = OP_HASH_INC;
          end
          default: cmd_o.op = OP_NONE;
        endcase
      end
      CS_JOIN:     cmd_o.op = OP_JOIN;
      CS_LEAD:     cmd_o.op = OP_LEAD_POP;
      CS_HASHES:   cmd_o.op = OP_HASH_POP;
      CS_TEXT:     cmd_o.op = OP_TEXT;
      CS_CLOSEH:   cmd_o.op = OP_PCLOSE;
      CS_HOPEN:    cmd_o.op = OP_HOPEN;
      CS_NEXT:     cmd_o.op = st_i.pend ? OP_NEXT_B : OP_NONE;
      CS_ELINE:    cmd_o.op = OP_SET_FLAG;
      CS_ELCLOSE:  cmd_o.op = OP_PCLOSE;
      CS_HCLOSE:   cmd_o.op = OP_HCLOSE;
      CS_ELDONE:   cmd_o.op = OP_LINE_RESET;
      CS_ENDCLOSE: cmd_o.op = OP_PCLOSE;
      CS_DOCEND:   cmd_o.op = OP_DOC_END;
      CS_FINISH:   cmd_o.op = OP_FINISH;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[sv/mbc_dp.sv]
// Datapath: line state, leading whitespace buffer, event stage and output register.
`default_nettype none

module mbc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbc_pkg::cmd_t    cmd_i,
  output mbc_pkg::status_t st_o,
  mbc_in_if.sink           in_i,
  mbc_out_if.source        out_o
);
  import mbc_pkg::*;

  logic [7:0]            byte_q, byte_d, cur_q, cur_d;
  logic                  end_q, end_d;
  logic                  pend_q, pend_d, held_q, held_d, para_q, para_d, flag_q, flag_d;
  phase_e                phase_q, phase_d;
  logic [2:0]            hc_q, hc_d, level_q, level_d;
  logic [LEAD_CNT_W-1:0] cnt_q, cnt_d;
  logic [LEAD_DEPTH-1:0] pat_q, pat_d;
  logic                  stage_v_q, stage_v_d, out_v_q, out_v_d, out_last_q, out_last_d;
  event_t                stage_q, stage_d, out_q, out_d, ev;
  logic                  in_fire, out_free, push_ok, emits, is_fin, op_done;
  logic                  b_is_cr, b_is_nl;

  assign in_i.ready = cmd_i.take;
  assign in_fire    = in_i.valid && cmd_i.take;
  assign b_is_cr    = (byte_q == CH_CR);
  assign b_is_nl    = (byte_q == CH_NL);
  assign out_free   = !out_v_q || out_o.ready;
  assign push_ok    = !stage_v_q || out_free;
  assign is_fin     = (cmd_i.op == OP_FINISH);

  // Event built by the current operation.
  always_comb begin
    emits    = 1'b0;
    ev.kind  = EV_TEXT;
    ev.data  = 8'h00;
    ev.level = 3'd0;
    ev.flag  = flag_q;
    case (cmd_i.op)
      OP_JOIN: begin
        emits = 1'b1;
        if (para_q) ev.data = CH_SPACE;
        else ev.kind = EV_P_OPEN;
      end
      OP_LEAD_POP: begin
        emits   = 1'b1;
        ev.data = pat_q[0] ? CH_TAB : CH_SPACE;
      end
      OP_HASH_POP: begin
        emits   = 1'b1;
        ev.data = CH_HASH;
      end
      OP_TEXT: begin
        emits   = 1'b1;
        ev.data = cur_q;
        ev.flag = 1'b0;
      end
      OP_PCLOSE: begin
        emits   = para_q;
        ev.kind = EV_P_CLOSE;
      end
      OP_HOPEN: begin
        emits    = 1'b1;
        ev.kind  = EV_H_OPEN;
        ev.level = hc_q;
      end
      OP_HCLOSE: begin
        emits   = 1'b1;
        ev.kind = EV_H_CLOSE;
      end
      OP_DOC_END: begin
        emits   = 1'b1;
        ev.kind = EV_DOC_END;
      end
      default: emits = 1'b0;
    endcase
  end

  assign op_done = (emits || is_fin) ? push_ok : 1'b1;

  // One event is held back so the last event of a transaction can be marked.
  always_comb begin
    stage_v_d  = stage_v_q;
    stage_d    = stage_q;
    out_v_d    = out_v_q && !out_o.ready;
    out_d      = out_q;
    out_last_d = out_last_q;
    if ((emits || is_fin) && push_ok) begin
      if (stage_v_q) begin
        out_v_d    = 1'b1;
        out_d      = stage_q;
        out_last_d = is_fin;
      end
      stage_v_d = emits;
      if (emits) stage_d = ev;
    end
  end

  // Line state updates.
  always_comb begin
    byte_d  = byte_q;
    end_d   = end_q;
    cur_d   = cur_q;
    pend_d  = pend_q;
    held_d  = held_q;
    para_d  = para_q;
    flag_d  = flag_q;
    phase_d = phase_q;
    hc_d    = hc_q;
    level_d = level_q;
    cnt_d   = cnt_q;
    pat_d   = pat_q;
    if (in_fire) begin
      byte_d = in_i.text_byte;
      end_d  = in_i.end_of_text;
    end
    if (op_done) begin
      case (cmd_i.op)
        OP_DISPATCH: begin
          if (!end_q && !b_is_nl) begin
            if (held_q) begin
              cur_d  = CH_CR;
              pend_d = !b_is_cr;
              held_d = b_is_cr;
            end else if (b_is_cr) begin
              held_d = 1'b1;
            end else begin
              cur_d  = byte_q;
              pend_d = 1'b0;
            end
          end
        end
        OP_LEAD_ADD: begin
          if (cnt_q < LEAD_CNT_W'(LEAD_DEPTH)) begin
            pat_d[cnt_q[LEAD_IDX_W-1:0]] = (cur_q == CH_TAB);
            cnt_d = cnt_q + LEAD_CNT_W'(1);
          end else begin
            phase_d = PH_OVER;
          end
        end
        OP_HASH_START: begin
          phase_d = PH_HASH;
          hc_d    = 3'd1;
        end
        OP_HASH_INC: hc_d = hc_q + 3'd1;
        OP_SET_FLAG: flag_d = (phase_q == PH_OVER);
        OP_NEXT_B: begin
          cur_d  = byte_q;
          pend_d = 1'b0;
        end
        OP_JOIN: para_d = 1'b1;
        OP_LEAD_POP: begin
          pat_d = pat_q >> 1;
          cnt_d = cnt_q - LEAD_CNT_W'(1);
        end
        OP_HASH_POP: hc_d = hc_q - 3'd1;
        OP_TEXT: begin
          phase_d = (phase_q == PH_GAP || phase_q == PH_BODY) ? PH_BODY : PH_PARA;
          flag_d  = 1'b0;
        end
        OP_PCLOSE: para_d = 1'b0;
        OP_HOPEN: begin
          level_d = hc_q;
          hc_d    = 3'd0;
          phase_d = PH_GAP;
        end
        OP_HCLOSE: level_d = 3'd0;
        OP_LINE_RESET, OP_DOC_END: begin
          phase_d = PH_LEAD;
          hc_d    = 3'd0;
          cnt_d   = '0;
          pat_d   = '0;
          held_d  = 1'b0;
          flag_d  = 1'b0;
          if (cmd_i.op == OP_DOC_END) begin
            para_d  = 1'b0;
            level_d = 3'd0;
            pend_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      held_q    <= 1'b0;
      para_q    <= 1'b0;
      flag_q    <= 1'b0;
      phase_q   <= PH_LEAD;
      hc_q      <= 3'd0;
      level_q   <= 3'd0;
      cnt_q     <= '0;
      pat_q     <= '0;
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      held_q    <= held_d;
      para_q    <= para_d;
      flag_q    <= flag_d;
      phase_q   <= phase_d;
      hc_q      <= hc_d;
      level_q   <= level_d;
      cnt_q     <= cnt_d;
      pat_q     <= pat_d;
      stage_v_q <= stage_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    end_q      <= end_d;
    cur_q      <= cur_d;
    stage_q    <= stage_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign st_o.phase      = phase_q;
  assign st_o.cur_ws     = (cur_q == CH_SPACE) || (cur_q == CH_TAB);
  assign st_o.cur_space  = (cur_q == CH_SPACE);
  assign st_o.cur_hash   = (cur_q == CH_HASH);
  assign st_o.lead_zero  = (cnt_q == '0);
  assign st_o.lead_one   = (cnt_q == LEAD_CNT_W'(1));
  assign st_o.hc_lt_max  = (hc_q < MAX_LEVEL);
  assign st_o.hc_one     = (hc_q == 3'd1);
  assign st_o.b_is_cr    = b_is_cr;
  assign st_o.is_eol     = end_q || b_is_nl;
  assign st_o.is_end     = end_q;
  assign st_o.held       = held_q;
  assign st_o.pend       = pend_q;
  assign st_o.in_heading = (level_q != 3'd0);
  assign st_o.stage_v    = stage_v_q;
  assign st_o.op_done    = op_done;
  assign st_o.in_fire    = in_fire;

  assign out_o.valid         = out_v_q;
  assign out_o.event_kind    = out_q.kind;
  assign out_o.out_byte      = out_q.data;
  assign out_o.head_level    = out_q.level;
  assign out_o.lead_overflow = out_q.flag;
  assign out_o.last_of_run   = out_last_q;

endmodule

`default_nettype wire
